// ===== design/phc_pkg.sv =====
// shared constants, types and arithmetic helpers for the pixel colorizer
package phc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 11;
  localparam int unsigned SatW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned Stages   = 6;

  localparam logic [HueW-1:0] HueMax   = 11'd1535;
  localparam logic [HueW-1:0] HueReset = 11'd128;
  localparam logic [SatW-1:0] SatMax   = 7'd100;

  // reciprocals: x/100 = (x*5243)>>19 for x <= 25500, x/3 = (x*683)>>11 for x <= 765
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam logic [9:0]  Recip3   = 10'd683;

  typedef enum logic [CfgIdxW-1:0] {
    RegHue  = 2'd0,
    RegSat  = 2'd1,
    RegMode = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } tint_t;

  // per-stage advance enables for the blend stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  // six 256-step segments around the colour wheel
  function automatic tint_t hue_to_tint(input logic [HueW-1:0] hue);
    tint_t            t;
    logic [ChanW-1:0] off;
    off = hue[7:0];
    case (hue[10:8])
      3'd0: begin t.r = 8'd255;      t.g = off;         t.b = 8'd0;        end
      3'd1: begin t.r = 8'd255 - off; t.g = 8'd255;     t.b = 8'd0;        end
      3'd2: begin t.r = 8'd0;        t.g = 8'd255;      t.b = off;         end
      3'd3: begin t.r = 8'd0;        t.g = 8'd255 - off; t.b = 8'd255;     end
      3'd4: begin t.r = off;         t.g = 8'd0;        t.b = 8'd255;      end
      default: begin t.r = 8'd255;   t.g = 8'd0;        t.b = 8'd255 - off; end
    endcase
    return t;
  endfunction

  // exact floor(p/255) for any 16-bit p <= 65279 (results up to 255)
  function automatic logic [ChanW-1:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== design/phc_blend.sv =====
// one colour channel of the blend: tint gray, weight against source, divide by 100
module phc_blend import phc_pkg::*; (
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  logic [ChanW-1:0] gray_i,
  input  logic [ChanW-1:0] chan_i,
  input  logic [ChanW-1:0] tint_i,
  input  logic [SatW-1:0]  sat_i,
  output logic [ChanW-1:0] chan_o
);

  logic [15:0]      pg_q, pg_d;
  logic [14:0]      pc_q, pc_d;
  logic [14:0]      qs_q, qs_d;
  logic [14:0]      pc4_q;
  logic [14:0]      sum_q, sum_d;
  logic [ChanW-1:0] out_q, out_d;
  logic [SatW-1:0]  inv_sat;
  logic [27:0]      recip;

  assign inv_sat = SatMax - sat_i;
  assign pg_d    = gray_i * tint_i;
  assign pc_d    = 15'(chan_i) * 15'(inv_sat);
  assign qs_d    = 15'(div255(pg_q)) * 15'(sat_i);
  assign sum_d   = qs_q + pc4_q;
  assign recip   = 28'(sum_q) * 28'(Recip100);
  assign out_d   = recip[26:19];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      pg_q <= pg_d;
      pc_q <= pc_d;
    end
    if (en_i.s4) begin
      qs_q  <= qs_d;
      pc4_q <= pc_q;
    end
    if (en_i.s5) begin
      sum_q <= sum_d;
    end
    if (en_i.s6) begin
      out_q <= out_d;
    end
  end

  assign chan_o = out_q;

endmodule

// ===== design/pixel_hue_colorize.sv =====
// colorizer top level: config registers, gray stages, three channel blends, handshake
//
// Pixel stream colorizer. Requests arrive on the input channel (in_valid_i,
// in_ready_o, pixel_in_i) with red in bits 23..16, green 15..8, blue 7..0,
// and leave on the output channel (out_valid_o, out_ready_i, pixel_out_o)
// in the same layout, one result per request, in order.
// Registers are written over the cfg channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i): index 0 hue (saturates at 1535), 1 saturation
// (low 7 bits, saturates at 100), 2 gray mode; other indexes are ignored. Writes are
// taken every cycle and should only be issued while the pipeline is empty.
// Throughput is one pixel per cycle while out_ready_i is high; results
// pass through the six-stage pipeline (gray sum, gray divide,
// products, divide by 255 and saturation weight, sum, divide by 100).
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver holds the result in the output stage while bubbles
// further back are still filled; in_ready_o drops only when every stage
// holds a request. Reset empties the pipeline and loads hue 128,
// saturation 100 and weighted gray mode.
module pixel_hue_colorize import phc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3*ChanW-1:0]  pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3*ChanW-1:0]  pixel_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [HueW-1:0] hue_q;
  logic [SatW-1:0] sat_q;
  logic            mode_q;

  logic [Stages:1]   valid_q;
  logic [Stages+1:1] en;
  stage_en_t         blend_en;
  tint_t             tint;

  logic [3*ChanW-1:0] pix1_q, pix2_q;
  logic [14:0]        sum_w_q, sum_w_d;
  logic [9:0]         sum_a_q, sum_a_d;
  logic [ChanW-1:0]   gray_q, gray_d;
  logic [27:0]        prod_w;
  logic [19:0]        prod_a;
  logic [8:0]         gray_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q  <= HueReset;
      sat_q  <= SatMax;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegHue:  hue_q  <= (cfg_data_i > HueMax) ? HueMax : cfg_data_i;
        RegSat:  sat_q  <= (cfg_data_i[SatW-1:0] > SatMax) ? SatMax : cfg_data_i[SatW-1:0];
        RegMode: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[Stages+1] = out_ready_i;
    for (int k = Stages; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 1: gray sums
  assign sum_w_d = 15'(pixel_in_i[23:16]) * 15'd11 + 15'(pixel_in_i[15:8]) * 15'd80
                 + 15'(pixel_in_i[7:0]) * 15'd9;
  assign sum_a_d = 10'(pixel_in_i[23:16]) + 10'(pixel_in_i[15:8]) + 10'(pixel_in_i[7:0]);

  // stage 2: divide by 100 or 3
  assign prod_w = 28'(sum_w_q) * 28'(Recip100);
  assign prod_a = 20'(sum_a_q) * 20'(Recip3);
  assign gray_w = prod_w[27:19];
  always_comb begin
    if (mode_q) begin
      gray_d = prod_a[18:11];
    end else if (gray_w > 9'd255) begin
      gray_d = 8'd255;
    end else begin
      gray_d = gray_w[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pix1_q  <= pixel_in_i;
      sum_w_q <= sum_w_d;
      sum_a_q <= sum_a_d;
    end
    if (en[2]) begin
      pix2_q <= pix1_q;
      gray_q <= gray_d;
    end
  end

  assign tint        = hue_to_tint(hue_q);
  assign blend_en.s3 = en[3];
  assign blend_en.s4 = en[4];
  assign blend_en.s5 = en[5];
  assign blend_en.s6 = en[6];

  phc_blend u_blend_r (
    .clk_i  (clk_i),
    .en_i   (blend_en),
    .gray_i (gray_q),
    .chan_i (pix2_q[23:16]),
    .tint_i (tint.r),
    .sat_i  (sat_q),
    .chan_o (pixel_out_o[23:16])
  );

  phc_blend u_blend_g (
    .clk_i  (clk_i),
    .en_i   (blend_en),
    .gray_i (gray_q),
    .chan_i (pix2_q[15:8]),
    .tint_i (tint.g),
    .sat_i  (sat_q),
    .chan_o (pixel_out_o[15:8])
  );

  phc_blend u_blend_b (
    .clk_i  (clk_i),
    .en_i   (blend_en),
    .gray_i (gray_q),
    .chan_i (pix2_q[7:0]),
    .tint_i (tint.b),
    .sat_i  (sat_q),
    .chan_o (pixel_out_o[7:0])
  );

  assign out_valid_o = valid_q[Stages];

endmodule
